FILE: sv/ipa_pkg.sv
// Shared types, constants and the capacity helper function of the slot index pool allocator.
package ipa_pkg;

  // Pool sizing
  localparam int MAX_SLOTS  = 256;
  localparam int SLOT_LIMIT = 256;
  localparam int POOL_LIMIT = (MAX_SLOTS < SLOT_LIMIT) ? MAX_SLOTS : SLOT_LIMIT;
  localparam int IDX_W      = 8;
  localparam int CNT_W      = 9;
  localparam int STAT_W     = 2;
  localparam int FUNC_W     = 2;

  // Request kinds
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESET = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EXHAUST  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_REJECTED = 2'd2;

  // Capacity register reset value
  localparam logic [CNT_W-1:0] CAPACITY_RESET = 9'd256;

  // One result transaction
  typedef struct packed {
    logic [CNT_W-1:0]  active_slots;
    logic [CNT_W-1:0]  free_slots;
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  granted_index;
  } ipa_result_t;

  // Capacity register value saturated to the pool size.
  function automatic logic [CNT_W-1:0] eff_capacity(input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] lim;
    lim = CNT_W'(POOL_LIMIT);
    return (cap > lim) ? lim : cap;
  endfunction

endpackage

FILE: sv/ipa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module ipa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds when no read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/ipa_core.sv
// Request sequencer of the allocator: free stack and active flag memories,
// read-modify-write of one request and the clearing pass after a pool reset.
module ipa_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ipa_pkg::CNT_W-1:0]   capacity,
  input  logic                        req_valid,
  input  logic [ipa_pkg::FUNC_W-1:0]  req_func,
  input  logic [ipa_pkg::IDX_W-1:0]   req_idx,
  output logic                        req_ready,
  input  logic                        res_room,
  output logic                        res_valid,
  output ipa_pkg::ipa_result_t        res
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [ipa_pkg::CNT_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [ipa_pkg::CNT_W-1:0]   cap_used_r, cap_used_nxt;
  logic [ipa_pkg::CNT_W-1:0]   free_top_r, free_top_nxt;
  logic [ipa_pkg::CNT_W-1:0]   active_total_r, active_total_nxt;
  logic [ipa_pkg::FUNC_W-1:0]  func_r;
  logic [ipa_pkg::IDX_W-1:0]   idx_r;

  logic                        accept;
  logic                        commit;
  logic                        stk_we, flg_we;
  logic [ipa_pkg::IDX_W-1:0]   stk_waddr, flg_waddr, stk_wdata, stk_raddr;
  logic                        flg_wdata;
  logic [ipa_pkg::IDX_W-1:0]   stk_rdata;
  logic                        flg_rdata;
  logic [ipa_pkg::CNT_W-1:0]   cap_new;
  logic [ipa_pkg::CNT_W-1:0]   clr_val;

  assign req_ready = (state_r == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign commit    = (state_r == ST_EXEC) && res_room;
  assign cap_new   = ipa_pkg::eff_capacity(capacity);
  assign clr_val   = cap_used_r - clr_cnt_r - ipa_pkg::CNT_W'(1);
  assign stk_raddr = ipa_pkg::IDX_W'(free_top_r - ipa_pkg::CNT_W'(1));

  // Free stack memory: one index per stack position.
  ipa_ram #(
    .WIDTH (ipa_pkg::IDX_W),
    .DEPTH (ipa_pkg::SLOT_LIMIT)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (accept),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Active flag memory: one bit per slot.
  ipa_ram #(
    .WIDTH (1),
    .DEPTH (ipa_pkg::SLOT_LIMIT)
  ) u_flag_ram (
    .clk   (clk),
    .we    (flg_we),
    .waddr (flg_waddr),
    .wdata (flg_wdata),
    .re    (accept),
    .raddr (req_idx),
    .rdata (flg_rdata)
  );

  // Request latch; the memories are read in the same cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= req_func;
      idx_r  <= req_idx;
    end
  end

  // Next state, memory writes and the result of the request in flight.
  always_comb begin
    state_nxt        = state_r;
    clr_cnt_nxt      = clr_cnt_r;
    cap_used_nxt     = cap_used_r;
    free_top_nxt     = free_top_r;
    active_total_nxt = active_total_r;
    stk_we           = 1'b0;
    stk_waddr        = clr_cnt_r[ipa_pkg::IDX_W-1:0];
    stk_wdata        = clr_val[ipa_pkg::IDX_W-1:0];
    flg_we           = 1'b0;
    flg_waddr        = clr_cnt_r[ipa_pkg::IDX_W-1:0];
    flg_wdata        = 1'b0;
    res_valid        = 1'b0;
    res.granted_index = '0;
    res.status        = ipa_pkg::STAT_OK;

    unique case (state_r)
      ST_CLEAR: begin
        // Clearing pass: refill one stack position and clear one flag a cycle.
        if (clr_cnt_r == cap_used_r) begin
          state_nxt = ST_IDLE;
        end else begin
          stk_we      = 1'b1;
          flg_we      = 1'b1;
          clr_cnt_nxt = clr_cnt_r + ipa_pkg::CNT_W'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          res_valid = 1'b1;
          state_nxt = ST_IDLE;
          unique case (func_r)
            ipa_pkg::FUNC_ALLOC: begin
              if (free_top_r == '0) begin
                res.status = ipa_pkg::STAT_EXHAUST;
              end else begin
                free_top_nxt      = free_top_r - ipa_pkg::CNT_W'(1);
                active_total_nxt  = active_total_r + ipa_pkg::CNT_W'(1);
                flg_we            = 1'b1;
                flg_waddr         = stk_rdata;
                flg_wdata         = 1'b1;
                res.granted_index = stk_rdata;
              end
            end
            ipa_pkg::FUNC_FREE: begin
              if (({1'b0, idx_r} >= cap_used_r) || !flg_rdata ||
                  (free_top_r >= cap_used_r)) begin
                res.status = ipa_pkg::STAT_REJECTED;
              end else begin
                flg_we           = 1'b1;
                flg_waddr        = idx_r;
                flg_wdata        = 1'b0;
                stk_we           = 1'b1;
                stk_waddr        = free_top_r[ipa_pkg::IDX_W-1:0];
                stk_wdata        = idx_r;
                free_top_nxt     = free_top_r + ipa_pkg::CNT_W'(1);
                active_total_nxt = active_total_r - ipa_pkg::CNT_W'(1);
              end
            end
            ipa_pkg::FUNC_RESET: begin
              cap_used_nxt     = cap_new;
              free_top_nxt     = cap_new;
              active_total_nxt = '0;
              clr_cnt_nxt      = '0;
              state_nxt        = ST_CLEAR;
            end
            default: begin
              // Unknown request kind: nothing changes.
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase

    res.free_slots   = free_top_nxt;
    res.active_slots = active_total_nxt;
  end

  // Control registers; hardware reset starts a clearing pass at full size.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_cnt_r      <= '0;
      cap_used_r     <= ipa_pkg::eff_capacity(ipa_pkg::CAPACITY_RESET);
      free_top_r     <= ipa_pkg::eff_capacity(ipa_pkg::CAPACITY_RESET);
      active_total_r <= '0;
    end else begin
      state_r        <= state_nxt;
      clr_cnt_r      <= clr_cnt_nxt;
      cap_used_r     <= cap_used_nxt;
      free_top_r     <= free_top_nxt;
      active_total_r <= active_total_nxt;
    end
  end

endmodule

FILE: sv/index_pool_allocator_top.sv
// Top level of the slot index pool allocator: stream ports, capacity register, result register.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+---------------------------------------------
//  cfg     | in        | cfg_valid/ready    | cfg_data: capacity
//  in      | in        | in_tvalid/tready   | tuser: func; tdata: slot_index
//  out     | out       | out_tvalid/tready  | tuser: status; tdata: granted, free, active
//
// A request is accepted when the sequencer is idle and the memories are read in that cycle;
// it is committed in the next cycle if the result register has room, else once it has room,
// and the result register takes its result on commit. No new request is accepted before
// the last one commits. A reset request (and hardware reset) is followed by a clearing pass,
// one entry a cycle, during which in_tready is low.
// While a result waits one more request can be accepted; its commit stalls until room.
module index_pool_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data,
  // Request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] slot_index
  input  logic [1:0]  in_tuser,   // [1:0] func
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] granted_index, [16:8] free_slots,
                                  // [25:17] active_slots, [31:26] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  logic [ipa_pkg::CNT_W-1:0] capacity_r;
  logic                      out_valid_r;
  ipa_pkg::ipa_result_t      out_res_r;
  logic                      res_valid;
  ipa_pkg::ipa_result_t      res;
  logic                      res_room;

  // Capacity register; takes effect at the next pool reset.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= ipa_pkg::CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_data;
    end
  end

  // The result register has room when empty or being drained this cycle.
  assign res_room = !out_valid_r || out_tready;

  ipa_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .capacity  (capacity_r),
    .req_valid (in_tvalid),
    .req_func  (in_tuser),
    .req_idx   (in_tdata),
    .req_ready (in_tready),
    .res_room  (res_room),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {6'd0, out_res_r.active_slots, out_res_r.free_slots,
                       out_res_r.granted_index};

endmodule
